// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

    // Fixed port field widths
    localparam int FUNC_W   = 1;
    localparam int BYTES_W  = 32;
    localparam int FPAGE_W  = 12;
    localparam int STATUS_W = 2;
    localparam int GPAGE_W  = 12;
    localparam int GORDER_W = 4;
    localparam int PFREE_W  = 13;

    // Operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    // Datapath operations issued by the controller
    typedef logic [5:0] op_t;

    localparam op_t OP_NOP       = 6'd0;
    localparam op_t OP_LOAD      = 6'd1;
    localparam op_t OP_CLR       = 6'd2;
    localparam op_t OP_SZ_PREP   = 6'd3;
    localparam op_t OP_ORD_STEP  = 6'd4;
    localparam op_t OP_MRG_INIT  = 6'd5;
    localparam op_t OP_MRG_HEAD  = 6'd6;
    localparam op_t OP_CUR_INC   = 6'd7;
    localparam op_t OP_CUR_DEC   = 6'd8;
    localparam op_t OP_LST_CUR   = 6'd9;
    localparam op_t OP_RD_B      = 6'd10;
    localparam op_t OP_RD_P      = 6'd11;
    localparam op_t OP_ADV       = 6'd12;
    localparam op_t OP_SEL_P     = 6'd13;
    localparam op_t OP_SEL_B     = 6'd14;
    localparam op_t OP_UNL_RD    = 6'd15;
    localparam op_t OP_UNL_A     = 6'd16;
    localparam op_t OP_UNL_B     = 6'd17;
    localparam op_t OP_UNL_C     = 6'd18;
    localparam op_t OP_MRG_HI    = 6'd19;
    localparam op_t OP_MRG_LO    = 6'd20;
    localparam op_t OP_PH_A      = 6'd21;
    localparam op_t OP_PH_B      = 6'd22;
    localparam op_t OP_PT_A      = 6'd23;
    localparam op_t OP_PT_B      = 6'd24;
    localparam op_t OP_SPL_INIT  = 6'd25;
    localparam op_t OP_SPL_SEL   = 6'd26;
    localparam op_t OP_SPL_ORD_P = 6'd27;
    localparam op_t OP_SPL_ORD_B = 6'd28;
    localparam op_t OP_ALC_SEL   = 6'd29;
    localparam op_t OP_ALC_FIN   = 6'd30;
    localparam op_t OP_F_RD      = 6'd31;
    localparam op_t OP_F_CHK     = 6'd32;
    localparam op_t OP_RES_SIZE  = 6'd33;
    localparam op_t OP_RES_NONE  = 6'd34;
    localparam op_t OP_RES_BADF  = 6'd35;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic func;        // latched operation is a free
        logic size_bad;    // request size outside one page to one top block
        logic sz_zero;     // order search finished
        logic head_nil;    // selected free list is empty
        logic cur_eq_tgt;  // working order reached target order
        logic cur_gt_top;  // working order beyond the top order
        logic buddy_match; // buddy read back is a free block of same order
        logic next_nil;    // record read back ends its list
        logic fpage_oob;   // page to free lies outside the region
        logic f_bad;       // page to free heads no block or is already free
        logic clr_last;    // clearing pass at its last entry
    } dp_stat_t;

endpackage

// ----- rtl/core/bpa_datapath.sv -----
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int TOP_ORDER  = 10,
    parameter int TOP_BLOCKS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FUNC_W-1:0]   func,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [FPAGE_W-1:0]  free_page,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic [STATUS_W-1:0] status,
    output logic [GPAGE_W-1:0]  granted_page,
    output logic [GORDER_W-1:0] granted_order,
    output logic [PFREE_W-1:0]  pages_free
);

    localparam int NPAGES = TOP_BLOCKS << TOP_ORDER;
    localparam int AW     = $clog2(NPAGES);
    localparam int LW     = AW + 1;
    localparam int OW     = $clog2(TOP_ORDER + 2);
    localparam int NORD   = 1 << OW;
    localparam int CW     = $clog2(NPAGES + 1);

    localparam logic [LW-1:0] NIL        = LW'(1) << AW;
    localparam logic [OW-1:0] ORD_TOP    = OW'(TOP_ORDER);
    localparam logic [OW-1:0] ORD_NONE   = OW'(TOP_ORDER + 1);
    localparam logic [AW:0]   TOP_STRIDE = (AW + 1)'(1) << TOP_ORDER;

    typedef logic [AW-1:0] page_t;
    typedef logic [LW-1:0] link_t;

    // Per-page stores
    logic [OW-1:0] order_mem [NPAGES];
    logic          free_mem  [NPAGES];
    link_t         next_mem  [NPAGES];
    link_t         prev_mem  [NPAGES];

    logic [OW-1:0] rd_order_reg;
    logic          rd_free_reg;
    link_t         rd_next_reg;
    link_t         rd_prev_reg;

    page_t         addr;
    logic          we_order, we_free, we_next, we_prev;
    logic [OW-1:0] wd_order;
    logic          wd_free;
    link_t         wd_next, wd_prev;

    // List ends and control state
    link_t         head_reg [NORD];
    link_t         tail_reg [NORD];
    logic          head_we, tail_we;
    link_t         head_wd, tail_wd;
    logic [CW-1:0] cnt_reg, cnt_next;
    page_t         clr_reg, clr_next;

    // Working registers
    logic [BYTES_W-1:0]  sz_reg, sz_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [FPAGE_W-1:0]  fp_reg, fp_next;
    logic [OW-1:0]       tgt_reg, tgt_next;
    logic [OW-1:0]       cur_reg, cur_next;
    logic [OW-1:0]       lst_reg, lst_next;
    page_t               p_reg, p_next;
    page_t               b_reg, b_next;
    page_t               q_reg, q_next;
    link_t               nx_reg, nx_next;
    link_t               pv_reg, pv_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    page_t               res_page_reg, res_page_next;
    logic [OW-1:0]       res_order_reg, res_order_next;

    link_t hd, tl;
    page_t fp_page, bsel, lo_page, hi_page;
    logic  clr_is_head;
    logic [AW:0] clr_up, clr_dn;

    assign hd      = head_reg[lst_reg];
    assign tl      = tail_reg[lst_reg];
    assign fp_page = AW'(fp_reg);
    assign lo_page = (p_reg < b_reg) ? p_reg : b_reg;
    assign hi_page = (p_reg < b_reg) ? b_reg : p_reg;
    assign bsel    = p_reg ^ (page_t'(1) << cur_reg);

    assign clr_is_head = (clr_reg[TOP_ORDER-1:0] == '0);
    assign clr_up      = {1'b0, clr_reg} + TOP_STRIDE;
    assign clr_dn      = {1'b0, clr_reg} - TOP_STRIDE;

    always_comb
    begin
        stat.func        = (func_reg == FUNC_FREE);
        stat.size_bad    = (sz_reg < (BYTES_W + 1)'(64'd1 << PAGE_BITS))
                        || ({1'b0, sz_reg} > (BYTES_W + 1)'(64'd1 << (PAGE_BITS + TOP_ORDER)));
        stat.sz_zero     = (sz_reg == '0);
        stat.head_nil    = hd[AW];
        stat.cur_eq_tgt  = (cur_reg == tgt_reg);
        stat.cur_gt_top  = (cur_reg > ORD_TOP);
        stat.buddy_match = rd_free_reg && (rd_order_reg == cur_reg);
        stat.next_nil    = rd_next_reg[AW];
        stat.fpage_oob   = (32'(fp_reg) >= 32'(NPAGES));
        stat.f_bad       = (rd_order_reg > ORD_TOP) || rd_free_reg;
        stat.clr_last    = (clr_reg == page_t'(NPAGES - 1));
    end

    always_comb
    begin
        addr     = q_reg;
        we_order = 1'b0;
        we_free  = 1'b0;
        we_next  = 1'b0;
        we_prev  = 1'b0;
        wd_order = '0;
        wd_free  = 1'b0;
        wd_next  = NIL;
        wd_prev  = NIL;
        head_we  = 1'b0;
        tail_we  = 1'b0;
        head_wd  = NIL;
        tail_wd  = NIL;
        cnt_next = cnt_reg;
        clr_next = clr_reg;

        sz_next         = sz_reg;
        func_next       = func_reg;
        fp_next         = fp_reg;
        tgt_next        = tgt_reg;
        cur_next        = cur_reg;
        lst_next        = lst_reg;
        p_next          = p_reg;
        b_next          = b_reg;
        q_next          = q_reg;
        nx_next         = nx_reg;
        pv_next         = pv_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_order_next  = res_order_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                func_next = func;
                sz_next   = request_bytes;
                fp_next   = free_page;
            end
            OP_CLR:
            begin
                addr     = clr_reg;
                we_order = 1'b1;
                we_free  = 1'b1;
                we_next  = 1'b1;
                we_prev  = 1'b1;
                wd_order = clr_is_head ? ORD_TOP : ORD_NONE;
                wd_free  = clr_is_head;
                wd_next  = (clr_is_head && (32'(clr_up) < 32'(NPAGES)))
                           ? {1'b0, clr_up[AW-1:0]} : NIL;
                wd_prev  = (clr_is_head && ({1'b0, clr_reg} >= TOP_STRIDE))
                           ? {1'b0, clr_dn[AW-1:0]} : NIL;
                clr_next = clr_reg + page_t'(1);
            end
            OP_SZ_PREP:
            begin
                sz_next  = (sz_reg - BYTES_W'(1)) >> PAGE_BITS;
                tgt_next = '0;
                lst_next = '0;
            end
            OP_ORD_STEP:
            begin
                sz_next  = sz_reg >> 1;
                tgt_next = tgt_reg + OW'(1);
                lst_next = tgt_reg + OW'(1);
            end
            OP_MRG_INIT:
            begin
                cur_next = '0;
                lst_next = '0;
            end
            OP_MRG_HEAD:
            begin
                p_next = hd[AW-1:0];
            end
            OP_CUR_INC:
            begin
                cur_next = cur_reg + OW'(1);
                lst_next = cur_reg + OW'(1);
            end
            OP_CUR_DEC:
            begin
                cur_next = cur_reg - OW'(1);
                lst_next = cur_reg - OW'(1);
            end
            OP_LST_CUR:
            begin
                lst_next = cur_reg;
            end
            OP_RD_B:
            begin
                addr   = bsel;
                b_next = bsel;
            end
            OP_RD_P:
            begin
                addr = p_reg;
            end
            OP_ADV:
            begin
                p_next = rd_next_reg[AW-1:0];
            end
            OP_SEL_P:
            begin
                q_next = p_reg;
            end
            OP_SEL_B:
            begin
                q_next = b_reg;
            end
            OP_UNL_RD:
            begin
                addr = q_reg;
            end
            OP_UNL_A:
            begin
                nx_next = rd_next_reg;
                pv_next = rd_prev_reg;
                if (rd_prev_reg[AW])
                begin
                    head_we = 1'b1;
                    head_wd = rd_next_reg;
                end
                else
                begin
                    addr    = rd_prev_reg[AW-1:0];
                    we_next = 1'b1;
                    wd_next = rd_next_reg;
                end
            end
            OP_UNL_B:
            begin
                if (nx_reg[AW])
                begin
                    tail_we = 1'b1;
                    tail_wd = pv_reg;
                end
                else
                begin
                    addr    = nx_reg[AW-1:0];
                    we_prev = 1'b1;
                    wd_prev = pv_reg;
                end
            end
            OP_UNL_C:
            begin
                addr    = q_reg;
                we_next = 1'b1;
                we_prev = 1'b1;
            end
            OP_MRG_HI:
            begin
                addr     = hi_page;
                we_order = 1'b1;
                wd_order = ORD_NONE;
                we_free  = 1'b1;
                wd_free  = 1'b0;
            end
            OP_MRG_LO:
            begin
                addr     = lo_page;
                we_order = 1'b1;
                wd_order = cur_reg + OW'(1);
                q_next   = lo_page;
                lst_next = cur_reg + OW'(1);
            end
            OP_PH_A:
            begin
                addr    = q_reg;
                we_next = 1'b1;
                wd_next = hd;
                we_prev = 1'b1;
                if (hd[AW])
                begin
                    tail_we = 1'b1;
                    tail_wd = {1'b0, q_reg};
                end
            end
            OP_PH_B:
            begin
                if (!hd[AW])
                begin
                    addr    = hd[AW-1:0];
                    we_prev = 1'b1;
                    wd_prev = {1'b0, q_reg};
                end
                head_we = 1'b1;
                head_wd = {1'b0, q_reg};
            end
            OP_PT_A:
            begin
                addr    = q_reg;
                we_next = 1'b1;
                we_prev = 1'b1;
                wd_prev = tl;
                if (tl[AW])
                begin
                    head_we = 1'b1;
                    head_wd = {1'b0, q_reg};
                end
            end
            OP_PT_B:
            begin
                if (!tl[AW])
                begin
                    addr    = tl[AW-1:0];
                    we_next = 1'b1;
                    wd_next = {1'b0, q_reg};
                end
                tail_we = 1'b1;
                tail_wd = {1'b0, q_reg};
            end
            OP_SPL_INIT:
            begin
                cur_next = tgt_reg + OW'(1);
                lst_next = tgt_reg + OW'(1);
            end
            OP_SPL_SEL:
            begin
                p_next = hd[AW-1:0];
                q_next = hd[AW-1:0];
            end
            OP_SPL_ORD_P:
            begin
                addr     = p_reg;
                we_order = 1'b1;
                wd_order = cur_reg - OW'(1);
                b_next   = p_reg ^ (page_t'(1) << (cur_reg - OW'(1)));
            end
            OP_SPL_ORD_B:
            begin
                addr     = b_reg;
                we_order = 1'b1;
                wd_order = cur_reg - OW'(1);
                we_free  = 1'b1;
                wd_free  = 1'b1;
                q_next   = p_reg;
                lst_next = cur_reg - OW'(1);
            end
            OP_ALC_SEL:
            begin
                q_next = hd[AW-1:0];
            end
            OP_ALC_FIN:
            begin
                addr            = q_reg;
                we_free         = 1'b1;
                wd_free         = 1'b0;
                cnt_next        = cnt_reg - (CW'(1) << tgt_reg);
                res_status_next = ST_OK;
                res_page_next   = q_reg;
                res_order_next  = tgt_reg;
            end
            OP_F_RD:
            begin
                addr = fp_page;
            end
            OP_F_CHK:
            begin
                if (stat.f_bad)
                begin
                    res_status_next = ST_BAD_FREE;
                    res_page_next   = '0;
                    res_order_next  = '0;
                end
                else
                begin
                    addr            = fp_page;
                    we_free         = 1'b1;
                    wd_free         = 1'b1;
                    q_next          = fp_page;
                    lst_next        = rd_order_reg;
                    cnt_next        = cnt_reg + (CW'(1) << rd_order_reg);
                    res_status_next = ST_OK;
                    res_page_next   = fp_page;
                    res_order_next  = rd_order_reg;
                end
            end
            OP_RES_SIZE:
            begin
                res_status_next = ST_BAD_SIZE;
                res_page_next   = '0;
                res_order_next  = '0;
            end
            OP_RES_NONE:
            begin
                res_status_next = ST_NO_BLOCK;
                res_page_next   = '0;
                res_order_next  = '0;
            end
            OP_RES_BADF:
            begin
                res_status_next = ST_BAD_FREE;
                res_page_next   = '0;
                res_order_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Single-port stores, registered read
    always_ff @(posedge clk)
    begin
        if (we_order)
            order_mem[addr] <= wd_order;
        rd_order_reg <= order_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_free)
            free_mem[addr] <= wd_free;
        rd_free_reg <= free_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_next)
            next_mem[addr] <= wd_next;
        rd_next_reg <= next_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_prev)
            prev_mem[addr] <= wd_prev;
        rd_prev_reg <= prev_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORD; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            head_reg[TOP_ORDER] <= '0;
            tail_reg[TOP_ORDER] <= LW'((TOP_BLOCKS - 1) << TOP_ORDER);
            cnt_reg <= CW'(NPAGES);
            clr_reg <= '0;
        end
        else
        begin
            if (head_we)
                head_reg[lst_reg] <= head_wd;
            if (tail_we)
                tail_reg[lst_reg] <= tail_wd;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sz_reg         <= sz_next;
        func_reg       <= func_next;
        fp_reg         <= fp_next;
        tgt_reg        <= tgt_next;
        cur_reg        <= cur_next;
        lst_reg        <= lst_next;
        p_reg          <= p_next;
        b_reg          <= b_next;
        q_reg          <= q_next;
        nx_reg         <= nx_next;
        pv_reg         <= pv_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_order_reg  <= res_order_next;
    end

    assign status        = res_status_reg;
    assign granted_page  = GPAGE_W'(res_page_reg);
    assign granted_order = GORDER_W'(res_order_reg);
    assign pages_free    = PFREE_W'(cnt_reg);

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [5:0] S_CLR     = 6'd0;
    localparam logic [5:0] S_IDLE    = 6'd1;
    localparam logic [5:0] S_DISP    = 6'd2;
    localparam logic [5:0] S_A_CHK   = 6'd3;
    localparam logic [5:0] S_A_ORD   = 6'd4;
    localparam logic [5:0] S_A_HEAD  = 6'd5;
    localparam logic [5:0] S_M_HEAD  = 6'd6;
    localparam logic [5:0] S_M_RDB   = 6'd7;
    localparam logic [5:0] S_M_CHK   = 6'd8;
    localparam logic [5:0] S_M_ADV   = 6'd9;
    localparam logic [5:0] S_M_UB    = 6'd10;
    localparam logic [5:0] S_M_HI    = 6'd11;
    localparam logic [5:0] S_M_LO    = 6'd12;
    localparam logic [5:0] S_M_RST   = 6'd13;
    localparam logic [5:0] S_S_INIT  = 6'd14;
    localparam logic [5:0] S_S_FIND  = 6'd15;
    localparam logic [5:0] S_S_OP    = 6'd16;
    localparam logic [5:0] S_S_OB    = 6'd17;
    localparam logic [5:0] S_S_PB    = 6'd18;
    localparam logic [5:0] S_S_DEC   = 6'd19;
    localparam logic [5:0] S_S_LOOP  = 6'd20;
    localparam logic [5:0] S_ALC     = 6'd21;
    localparam logic [5:0] S_ALC_FIN = 6'd22;
    localparam logic [5:0] S_F_RD    = 6'd23;
    localparam logic [5:0] S_F_CHK   = 6'd24;
    localparam logic [5:0] S_U0      = 6'd25;
    localparam logic [5:0] S_U1      = 6'd26;
    localparam logic [5:0] S_U2      = 6'd27;
    localparam logic [5:0] S_U3      = 6'd28;
    localparam logic [5:0] S_PH0     = 6'd29;
    localparam logic [5:0] S_PH1     = 6'd30;
    localparam logic [5:0] S_PT0     = 6'd31;
    localparam logic [5:0] S_PT1     = 6'd32;
    localparam logic [5:0] S_DONE    = 6'd33;

    logic [5:0] state_reg, state_next;
    logic [5:0] ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NOP;

        case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
                state_next = stat.func ? S_F_RD : S_A_CHK;
            S_A_CHK:
            begin
                if (stat.size_bad)
                begin
                    cmd.op     = OP_RES_SIZE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SZ_PREP;
                    state_next = S_A_ORD;
                end
            end
            S_A_ORD:
            begin
                if (stat.sz_zero)
                    state_next = S_A_HEAD;
                else
                    cmd.op = OP_ORD_STEP;
            end
            S_A_HEAD:
            begin
                if (!stat.head_nil)
                    state_next = S_ALC;
                else
                begin
                    cmd.op     = OP_MRG_INIT;
                    state_next = S_M_HEAD;
                end
            end
            S_M_HEAD:
            begin
                if (stat.cur_eq_tgt)
                    state_next = S_S_INIT;
                else if (stat.head_nil)
                    cmd.op = OP_CUR_INC;
                else
                begin
                    cmd.op     = OP_MRG_HEAD;
                    state_next = S_M_RDB;
                end
            end
            S_M_RDB:
            begin
                cmd.op     = OP_RD_B;
                state_next = S_M_CHK;
            end
            S_M_CHK:
            begin
                if (stat.buddy_match)
                begin
                    cmd.op     = OP_SEL_P;
                    state_next = S_U0;
                    ret_next   = S_M_UB;
                end
                else
                begin
                    cmd.op     = OP_RD_P;
                    state_next = S_M_ADV;
                end
            end
            S_M_ADV:
            begin
                if (stat.next_nil)
                begin
                    cmd.op     = OP_CUR_INC;
                    state_next = S_M_HEAD;
                end
                else
                begin
                    cmd.op     = OP_ADV;
                    state_next = S_M_RDB;
                end
            end
            S_M_UB:
            begin
                cmd.op     = OP_SEL_B;
                state_next = S_U0;
                ret_next   = S_M_HI;
            end
            S_M_HI:
            begin
                cmd.op     = OP_MRG_HI;
                state_next = S_M_LO;
            end
            S_M_LO:
            begin
                cmd.op     = OP_MRG_LO;
                state_next = S_PH0;
                ret_next   = S_M_RST;
            end
            S_M_RST:
            begin
                cmd.op     = OP_LST_CUR;
                state_next = S_M_HEAD;
            end
            S_S_INIT:
            begin
                if (!stat.head_nil)
                    state_next = S_ALC;
                else
                begin
                    cmd.op     = OP_SPL_INIT;
                    state_next = S_S_FIND;
                end
            end
            S_S_FIND:
            begin
                if (stat.cur_gt_top)
                begin
                    cmd.op     = OP_RES_NONE;
                    state_next = S_DONE;
                end
                else if (stat.head_nil)
                    cmd.op = OP_CUR_INC;
                else
                begin
                    cmd.op     = OP_SPL_SEL;
                    state_next = S_U0;
                    ret_next   = S_S_OP;
                end
            end
            S_S_OP:
            begin
                cmd.op     = OP_SPL_ORD_P;
                state_next = S_S_OB;
            end
            S_S_OB:
            begin
                cmd.op     = OP_SPL_ORD_B;
                state_next = S_PT0;
                ret_next   = S_S_PB;
            end
            S_S_PB:
            begin
                cmd.op     = OP_SEL_B;
                state_next = S_PT0;
                ret_next   = S_S_DEC;
            end
            S_S_DEC:
            begin
                cmd.op     = OP_CUR_DEC;
                state_next = S_S_LOOP;
            end
            S_S_LOOP:
            begin
                if (stat.cur_eq_tgt)
                    state_next = S_ALC;
                else
                begin
                    cmd.op     = OP_SPL_SEL;
                    state_next = S_U0;
                    ret_next   = S_S_OP;
                end
            end
            S_ALC:
            begin
                if (stat.head_nil)
                begin
                    cmd.op     = OP_RES_NONE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_ALC_SEL;
                    state_next = S_U0;
                    ret_next   = S_ALC_FIN;
                end
            end
            S_ALC_FIN:
            begin
                cmd.op     = OP_ALC_FIN;
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                if (stat.fpage_oob)
                begin
                    cmd.op     = OP_RES_BADF;
                    state_next = S_F_CHK;
                end
                else
                begin
                    cmd.op     = OP_F_RD;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (stat.fpage_oob)
                begin
                    cmd.op     = OP_NOP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_F_CHK;
                    if (stat.f_bad)
                        state_next = S_DONE;
                    else
                    begin
                        state_next = S_PH0;
                        ret_next   = S_DONE;
                    end
                end
            end
            S_U0:
            begin
                cmd.op     = OP_UNL_RD;
                state_next = S_U1;
            end
            S_U1:
            begin
                cmd.op     = OP_UNL_A;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd.op     = OP_UNL_B;
                state_next = S_U3;
            end
            S_U3:
            begin
                cmd.op     = OP_UNL_C;
                state_next = ret_reg;
            end
            S_PH0:
            begin
                cmd.op     = OP_PH_A;
                state_next = S_PH1;
            end
            S_PH1:
            begin
                cmd.op     = OP_PH_B;
                state_next = ret_reg;
            end
            S_PT0:
            begin
                cmd.op     = OP_PT_A;
                state_next = S_PT1;
            end
            S_PT1:
            begin
                cmd.op     = OP_PT_B;
                state_next = ret_reg;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ----- rtl/core/buddy_page_allocator_top.sv -----
// Buddy page allocator over TOP_BLOCKS top blocks of 2^TOP_ORDER pages each.
// Issue a transaction by raising start while busy is low; func selects
// allocate (size in request_bytes) or free (page in free_page). The result
// appears on status, granted_page, granted_order and pages_free with done, which is
// high for exactly one cycle; the receiver cannot stall it, so capture it then.
// After reset the block runs a clearing pass over the per-page stores and
// holds busy high until the pass ends. An allocation is served straight
// from its list when that list holds a block; when it is empty the
// sequencer first merges buddy pairs from the lower lists, then splits a
// larger block one level at a time. The timing of every transaction is set
// by the single-port page stores, which the sequencer visits one access
// per cycle.
module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int TOP_ORDER  = 10,
    parameter int TOP_BLOCKS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic [FUNC_W-1:0]   func,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [FPAGE_W-1:0]  free_page,
    output logic [STATUS_W-1:0] status,
    output logic [GPAGE_W-1:0]  granted_page,
    output logic [GORDER_W-1:0] granted_order,
    output logic [PFREE_W-1:0]  pages_free
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: walks merge, split and list maintenance one step at a time
    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Page stores, list ends, free count and result registers
    bpa_datapath #(
        .PAGE_BITS  (PAGE_BITS),
        .TOP_ORDER  (TOP_ORDER),
        .TOP_BLOCKS (TOP_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .request_bytes (request_bytes),
        .free_page     (free_page),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .granted_page  (granted_page),
        .granted_order (granted_order),
        .pages_free    (pages_free)
    );

endmodule
